@@ sv/delimited_frame_deframer_unit_assert.svh @@
// Assertion macros used by the deframer core (dfd_core).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef DELIMITED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define DELIMITED_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication.
`define DFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

@@ sv/dfd_pkg.sv @@
package dfd_pkg;

    localparam int PAYLOAD_LIMIT_DEF = 256;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    // Header byte positions, little-endian fields.
    localparam logic [2:0] HDR_TYPE   = 3'd0;
    localparam logic [2:0] HDR_SEQ_LO = 3'd1;
    localparam logic [2:0] HDR_SEQ_HI = 3'd2;
    localparam logic [2:0] HDR_LEN_B0 = 3'd3;
    localparam logic [2:0] HDR_LEN_B1 = 3'd4;
    localparam logic [2:0] HDR_LEN_B2 = 3'd5;
    localparam logic [2:0] HDR_LEN_B3 = 3'd6;
    localparam int         HEADER_BYTES = 7;

    // Reported length saturates at this value.
    localparam logic [8:0] LEN_SAT = 9'h1FF;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_END_FIRST    = 2'd2;
    localparam logic [1:0] REG_END_SECOND   = 2'd3;

    localparam logic [7:0] START_FIRST_RST  = 8'hCA;
    localparam logic [7:0] START_SECOND_RST = 8'hFE;
    localparam logic [7:0] END_FIRST_RST    = 8'hEF;
    localparam logic [7:0] END_SECOND_RST   = 8'hBE;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] end_first;
        logic [7:0] end_second;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_type;
        logic [15:0] sequence_res;
        logic [8:0]  frame_length;
        logic [15:0] check_received;
    } result_t;

endpackage

@@ sv/dfd_cfg.sv @@
module dfd_cfg
    import dfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_FIRST:  cfg_next.start_first  = cfg_data;
                REG_START_SECOND: cfg_next.start_second = cfg_data;
                REG_END_FIRST:    cfg_next.end_first    = cfg_data;
                REG_END_SECOND:   cfg_next.end_second   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first  <= START_FIRST_RST;
            cfg_reg.start_second <= START_SECOND_RST;
            cfg_reg.end_first    <= END_FIRST_RST;
            cfg_reg.end_second   <= END_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/dfd_in_stage.sv @@
module dfd_in_stage
    import dfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // The register is free when empty or when its byte is consumed this cycle.
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

@@ sv/dfd_core.sv @@
`include "delimited_frame_deframer_unit_assert.svh"

module dfd_core
    import dfd_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       advance,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    res
);

    localparam int CntW = ($clog2(PAYLOAD_LIMIT + 1) > 3) ? $clog2(PAYLOAD_LIMIT + 1) : 3;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHK_LO,
        PH_CHK_HI,
        PH_END1,
        PH_END2
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [7:0]      type_reg, type_next;
    logic [15:0]     seq_reg, seq_next;
    // Length is kept as its low 16 bits plus a flag for any set upper bit.
    logic [15:0]     len_lo_reg, len_lo_next;
    logic            len_hi_reg, len_hi_next;
    logic [15:0]     check_reg, check_next;
    logic            out_valid_reg, out_valid_next;
    result_t         res_reg, res_next;

    logic [15:0]     upd_lo;
    logic            upd_hi;
    logic [8:0]      len_sat;
    logic            too_long;
    logic            emit;
    logic            rearm;
    logic [1:0]      e_kind;
    logic [7:0]      e_data;
    logic [7:0]      e_idx;
    logic [15:0]     e_chk;

    assign advance  = byte_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        check_next = check_reg;
        upd_lo     = len_lo_reg;
        upd_hi     = len_hi_reg;
        too_long   = 1'b0;
        emit       = 1'b0;
        rearm      = 1'b0;
        e_kind     = KIND_DROP;
        e_data     = 8'd0;
        e_idx      = 8'd0;
        e_chk      = 16'd0;

        if (advance)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (byte_data == cfg.start_first)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    count_next = '0;
                    if (byte_data == cfg.start_second)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else if (byte_data == cfg.start_first)
                    begin
                        phase_next = PH_HUNT2;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HEADER:
                begin
                    case (count_reg[2:0])
                        HDR_TYPE:   type_next       = byte_data;
                        HDR_SEQ_LO: seq_next[7:0]   = byte_data;
                        HDR_SEQ_HI: seq_next[15:8]  = byte_data;
                        HDR_LEN_B0: upd_lo[7:0]     = byte_data;
                        HDR_LEN_B1: upd_lo[15:8]    = byte_data;
                        HDR_LEN_B2: upd_hi          = len_hi_reg || (byte_data != 8'd0);
                        HDR_LEN_B3: upd_hi          = len_hi_reg || (byte_data != 8'd0);
                        default:    upd_hi          = len_hi_reg;
                    endcase
                    count_next = count_reg + CntW'(1);
                    if (count_reg[2:0] == HDR_LEN_B3)
                    begin
                        count_next = '0;
                        too_long   = upd_hi || (upd_lo > 16'(PAYLOAD_LIMIT));
                        if (too_long)
                        begin
                            emit  = 1'b1;
                            rearm = 1'b1;
                        end
                        else if (upd_lo != 16'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = PH_CHK_LO;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_PAYLOAD;
                    e_data     = byte_data;
                    e_idx      = 8'(count_reg);
                    count_next = count_reg + CntW'(1);
                    if (16'(count_next) >= len_lo_reg)
                    begin
                        phase_next = PH_CHK_LO;
                    end
                end
                PH_CHK_LO:
                begin
                    check_next = {8'd0, byte_data};
                    phase_next = PH_CHK_HI;
                end
                PH_CHK_HI:
                begin
                    check_next[15:8] = byte_data;
                    phase_next       = PH_END1;
                end
                PH_END1:
                begin
                    if (byte_data == cfg.end_first)
                    begin
                        phase_next = PH_END2;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        rearm = 1'b1;
                        e_chk = check_reg;
                    end
                end
                PH_END2:
                begin
                    emit   = 1'b1;
                    rearm  = 1'b1;
                    e_chk  = check_reg;
                    e_kind = (byte_data == cfg.end_second) ? KIND_ACCEPT : KIND_DROP;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase

            if (rearm)
            begin
                count_next = '0;
                // A failed first end byte that is itself a start byte re-arms.
                if ((phase_reg == PH_END1) && (byte_data == cfg.start_first))
                begin
                    phase_next = PH_HUNT2;
                end
                else
                begin
                    phase_next = PH_HUNT1;
                end
            end
        end

        len_lo_next = rearm ? 16'd0 : upd_lo;
        len_hi_next = rearm ? 1'b0 : upd_hi;
        len_sat     = (upd_hi || (upd_lo[15:9] != 7'd0)) ? LEN_SAT : upd_lo[8:0];

        res_next.out_kind       = e_kind;
        res_next.data_byte      = e_data;
        res_next.byte_index     = e_idx;
        res_next.frame_type     = type_next;
        res_next.sequence_res   = seq_next;
        res_next.frame_length   = len_sat;
        res_next.check_received = e_chk;

        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            count_reg     <= '0;
            type_reg      <= 8'd0;
            seq_reg       <= 16'd0;
            len_lo_reg    <= 16'd0;
            len_hi_reg    <= 1'b0;
            check_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            type_reg      <= type_next;
            seq_reg       <= seq_next;
            len_lo_reg    <= len_lo_next;
            len_hi_reg    <= len_hi_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
            if (advance && emit)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    `DFD_ASSERT_NOW(a_payload_in_range, phase_reg == PH_PAYLOAD,
        !len_hi_reg && (16'(count_reg) < len_lo_reg))
    `DFD_ASSERT_NOW(a_header_count, phase_reg == PH_HEADER, count_reg < CntW'(HEADER_BYTES))
    `DFD_ASSERT_NOW(a_payload_has_length, out_valid_reg && (res_reg.out_kind == KIND_PAYLOAD),
        res_reg.frame_length != 9'd0)
    `DFD_ASSERT_NOW(a_frame_result_clean, out_valid_reg && (res_reg.out_kind != KIND_PAYLOAD),
        (res_reg.data_byte == 8'd0) && (res_reg.byte_index == 8'd0))
    `DFD_ASSERT_NEXT(a_check_to_end, advance && (phase_reg == PH_CHK_HI), phase_reg == PH_END1)

endmodule

@@ sv/delimited_frame_deframer_unit.sv @@
// A byte is captured in the input register, and the result register loads from it when
// the core consumes the byte, so its item is valid once the result register holds it.
// Throughput: one byte per clock; the input register and the result register each take
// a new item while the other side is still occupied, so only a stalled output holds up input.
// Reset: asynchronous, active low; the deframer hunts for the first start byte, the
// delimiter registers return to CA, FE, EF and BE (hex), and no result is pending.
//
// Structure: the received byte is captured in an input register (dfd_in_stage). The
// deframing state machine (dfd_core) consumes that byte and, when the byte
// produces a payload, accepted-frame or dropped-frame item, loads the result register
// that drives the output ports. The delimiter values live in dfd_cfg and may only be
// rewritten while the block is idle.
//
// The frame header is seven little-endian bytes: type, a 16-bit sequence number and a
// 32-bit payload length. Lengths above PAYLOAD_LIMIT drop the frame at once. Payload
// bytes are forwarded as they arrive with their position in the payload. The 16-bit check
// value that follows is not verified; it is reported with the frame's closing item.
module delimited_frame_deframer_unit
    import dfd_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Byte input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic [7:0]  frame_type,
    output logic [15:0] sequence_res,
    output logic [8:0]  frame_length,
    output logic [15:0] check_received
);

    cfg_t       cfg;
    result_t    res;
    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;

    // Delimiter registers.
    dfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register; it frees itself whenever the core consumes its byte.
    dfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Deframing state machine and result register.
    dfd_core #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    assign out_kind       = res.out_kind;
    assign data_byte      = res.data_byte;
    assign byte_index     = res.byte_index;
    assign frame_type     = res.frame_type;
    assign sequence_res   = res.sequence_res;
    assign frame_length   = res.frame_length;
    assign check_received = res.check_received;

endmodule

@@ bench/delimited_frame_deframer_unit_tb.sv @@
module delimited_frame_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfd_pkg::*;

    // Half of the 12 ns clock period.
    localparam int CLK_HALF = 6;
    // Generous ceiling on the whole run, in clock cycles.
    localparam int LIMIT_CYCLES = 200000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed for a byte that causes no result to clear the input
    // register and the state machine before a register write or the end.
    localparam int SETTLE_CYCLES = 4;
    // Random bytes that reach the state machine beyond the hunt, per phase.
    localparam int RANDOM_PER_PHASE = 175;

    // Our own copy of the deframer's position in the frame.
    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHK_LO,
        PH_CHK_HI,
        PH_END1,
        PH_END2
    } deframe_phase_t;

    // How a frame built by the stimulus is closed.
    typedef enum {
        END_GOOD,
        END_BAD_FIRST,
        END_REARM,
        END_BAD_SECOND
    } frame_end_t;

    // Every input starts at a known value.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_START_FIRST;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [8:0]  frame_length;
    logic [15:0] check_received;

    // Idling controls, in percent of cycles.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        long_hold = 1'b0;
    event        begin_hold;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    // Bytes accepted while the deframer was past the hunt for the first start byte.
    int unsigned framed_bytes = 0;

    // Predicted state of the deframer and its delimiter registers.
    deframe_phase_t frame_phase = PH_HUNT1;
    logic [8:0]     hdr_count = '0;
    logic [7:0]     type_seen = '0;
    logic [15:0]    seq_seen = '0;
    logic [31:0]    len_seen = '0;
    logic [15:0]    check_seen = '0;
    cfg_t           delims = {START_FIRST_RST, START_SECOND_RST, END_FIRST_RST, END_SECOND_RST};

    // Items the deframer still owes us, oldest first.
    result_t pending_frame_items[$];

    delimited_frame_deframer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .frame_type     (frame_type),
        .sequence_res   (sequence_res),
        .frame_length   (frame_length),
        .check_received (check_received)
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog: a run that hangs is a failed run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t ns: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("FAILURE");
            $finish;
        end
    end

    // The long hold-off counts its own cycles, so the stimulus can carry on
    // offering bytes while the result side stays shut.
    always
    begin
        @(begin_hold);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Receiver stall, drawn afresh each cycle.
    always @(posedge clk)
        out_stall <= long_hold || ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Queue one expected item; the header fields come from the current frame,
    // with the reported length saturating when it does not fit in nine bits.
    function automatic void expect_item(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [7:0] idx, input logic [15:0] chk);
        result_t item;
        item.out_kind       = kind;
        item.data_byte      = data;
        item.byte_index     = idx;
        item.frame_type     = type_seen;
        item.sequence_res   = seq_seen;
        item.frame_length   = (len_seen > 32'd511) ? LEN_SAT : len_seen[8:0];
        item.check_received = chk;
        pending_frame_items.push_back(item);
    endfunction

    // Back to the hunt once a frame has been closed or thrown away.
    function automatic void restart_hunt();
        frame_phase = PH_HUNT1;
        hdr_count   = '0;
        len_seen    = '0;
    endfunction

    // Advance the predicted deframer by one accepted byte.
    function automatic void deframe_byte(input logic [7:0] b);
        if (frame_phase != PH_HUNT1)
            framed_bytes++;
        case (frame_phase)
            PH_HUNT1:
                if (b == delims.start_first)
                    frame_phase = PH_HUNT2;
            PH_HUNT2:
            begin
                hdr_count = '0;
                // A repeated first start byte keeps the hunt armed.
                if (b == delims.start_second)
                    frame_phase = PH_HEADER;
                else if (b == delims.start_first)
                    frame_phase = PH_HUNT2;
                else
                    frame_phase = PH_HUNT1;
            end
            PH_HEADER:
            begin
                case (hdr_count[2:0])
                    HDR_TYPE:   type_seen        = b;
                    HDR_SEQ_LO: seq_seen[7:0]    = b;
                    HDR_SEQ_HI: seq_seen[15:8]   = b;
                    HDR_LEN_B0: len_seen[7:0]    = b;
                    HDR_LEN_B1: len_seen[15:8]   = b;
                    HDR_LEN_B2: len_seen[23:16]  = b;
                    default:    len_seen[31:24]  = b;
                endcase
                hdr_count++;
                if (hdr_count >= HEADER_BYTES)
                begin
                    hdr_count = '0;
                    if (len_seen > PAYLOAD_LIMIT_DEF)
                    begin
                        expect_item(KIND_DROP, 8'h00, 8'h00, 16'h0000);
                        restart_hunt();
                    end
                    else if (len_seen != 0)
                        frame_phase = PH_PAYLOAD;
                    else
                        frame_phase = PH_CHK_LO;
                end
            end
            PH_PAYLOAD:
            begin
                expect_item(KIND_PAYLOAD, b, hdr_count[7:0], 16'h0000);
                hdr_count++;
                if (hdr_count >= len_seen)
                    frame_phase = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                check_seen  = {8'h00, b};
                frame_phase = PH_CHK_HI;
            end
            PH_CHK_HI:
            begin
                check_seen[15:8] = b;
                frame_phase      = PH_END1;
            end
            PH_END1:
                if (b == delims.end_first)
                    frame_phase = PH_END2;
                else
                begin
                    expect_item(KIND_DROP, 8'h00, 8'h00, check_seen);
                    restart_hunt();
                    if (b == delims.start_first)
                        frame_phase = PH_HUNT2;
                end
            default:
            begin
                expect_item((b == delims.end_second) ? KIND_ACCEPT : KIND_DROP,
                            8'h00, 8'h00, check_seen);
                restart_hunt();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every item taken from the result side is matched against the oldest
    // prediction. Outputs are read in the active region of the edge, so they
    // still hold the values of the cycle that the edge closes.
    always @(posedge clk)
    begin
        result_t want_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frame_items.size() == 0)
            begin
                $display("%0t ns: item expected none, actual kind %0d data 0x%0h index %0d",
                         $time, out_kind, data_byte, byte_index);
                mismatch_count++;
            end
            else
            begin
                want_item = pending_frame_items.pop_front();
                check_field("out_kind", 32'(want_item.out_kind), 32'(out_kind));
                check_field("data_byte", 32'(want_item.data_byte), 32'(data_byte));
                check_field("byte_index", 32'(want_item.byte_index), 32'(byte_index));
                check_field("frame_type", 32'(want_item.frame_type), 32'(frame_type));
                check_field("sequence_res", 32'(want_item.sequence_res),
                            32'(sequence_res));
                check_field("frame_length", 32'(want_item.frame_length),
                            32'(frame_length));
                check_field("check_received", 32'(want_item.check_received),
                            32'(check_received));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. The idle decision is
    // made before the byte is offered, so valid never follows the stall.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deframe_byte(b);
    endtask

    // Stop offering, let every owed item arrive, then give the last bytes that
    // cause no item time to pass through the block.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frame_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Rewrite all four delimiters while the block is idle. The write enable
    // stays high across the burst so it is never dropped and raised in one step.
    task automatic apply_delimiters(input cfg_t s);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_FIRST;
        cfg_data  <= s.start_first;
        @(posedge clk);
        cfg_index <= REG_START_SECOND;
        cfg_data  <= s.start_second;
        @(posedge clk);
        cfg_index <= REG_END_FIRST;
        cfg_data  <= s.end_first;
        @(posedge clk);
        cfg_index <= REG_END_SECOND;
        cfg_data  <= s.end_second;
        @(posedge clk);
        cfg_we <= 1'b0;
        delims = s;
    endtask

    // Payload and noise bytes lean towards the delimiter values so that false
    // starts and false ends inside a frame turn up often.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0:       return delims.start_first;
            1:       return delims.start_second;
            2:       return delims.end_first;
            3:       return delims.end_second;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Send a whole frame. With rearmed set the first start byte is left out,
    // for use straight after a frame that ended on a start byte.
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] seq,
                              input logic [31:0] len, input frame_end_t ending,
                              input bit rearmed);
        logic [15:0] chk;
        logic [7:0]  first_end;
        logic [7:0]  second_end;
        chk        = 16'($urandom_range(16'hFFFF));
        first_end  = delims.end_first;
        second_end = delims.end_second;
        if (!rearmed)
            send_byte(delims.start_first);
        send_byte(delims.start_second);
        send_byte(ftype);
        send_byte(seq[7:0]);
        send_byte(seq[15:8]);
        for (int i = 0; i < 4; i++)
            send_byte(len[8*i +: 8]);
        // An over-long frame is thrown away at the end of its header.
        if (len > PAYLOAD_LIMIT_DEF)
            return;
        for (int i = 0; i < len; i++)
            send_byte(random_byte());
        send_byte(chk[7:0]);
        send_byte(chk[15:8]);
        case (ending)
            END_BAD_FIRST:
                do
                    first_end = 8'($urandom_range(255));
                while (first_end == delims.end_first || first_end == delims.start_first);
            END_REARM:
                first_end = delims.start_first;
            END_BAD_SECOND:
                do
                    second_end = 8'($urandom_range(255));
                while (second_end == delims.end_second);
            default:
                ;
        endcase
        send_byte(first_end);
        if (ending == END_GOOD || ending == END_BAD_SECOND)
            send_byte(second_end);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frames with the header fields at their extremes.
    task automatic test_frame_cases();
        send_frame(8'hFF, 16'hFFFF, 32'd0, END_GOOD, 1'b0);
        send_frame(8'h00, 16'h0000, 32'd1, END_GOOD, 1'b0);
        send_frame(8'hA5, 16'h5AA5, 32'd3, END_GOOD, 1'b0);
    endtask

    // A run of first start bytes stays armed; a wrong second byte goes back
    // to the hunt and the next frame must still be found.
    task automatic test_repeated_start();
        send_byte(delims.start_first);
        send_byte(delims.start_first);
        send_frame(8'h11, 16'h0102, 32'd2, END_GOOD, 1'b0);
        send_byte(delims.start_first);
        send_byte(8'h00);
        send_frame(8'h22, 16'h0304, 32'd1, END_GOOD, 1'b0);
    endtask

    // Frames closed badly: a wrong first end byte, a first end byte that is
    // itself a start byte and so re-arms the hunt, and a wrong second end byte.
    task automatic test_bad_endings();
        send_frame(8'h31, 16'h1111, 32'd2, END_BAD_FIRST, 1'b0);
        send_frame(8'h32, 16'h2222, 32'd1, END_REARM, 1'b0);
        send_frame(8'h33, 16'h3333, 32'd2, END_GOOD, 1'b1);
        send_frame(8'h34, 16'h4444, 32'd0, END_BAD_SECOND, 1'b0);
    endtask

    // The payload limit itself is accepted; anything above drops the frame at
    // the header, and the reported length saturates once past nine bits.
    task automatic test_length_limit();
        send_frame(8'h41, 16'h8001, 32'd256, END_GOOD, 1'b0);
        send_frame(8'h42, 16'h8002, 32'd257, END_GOOD, 1'b0);
        send_frame(8'h43, 16'h8003, 32'd512, END_GOOD, 1'b0);
        send_frame(8'h44, 16'h8004, 32'h0001_0000, END_GOOD, 1'b0);
        send_frame(8'h45, 16'h8005, 32'hFFFF_FFFF, END_GOOD, 1'b0);
    endtask

    // Each delimiter setting, extremes first, carries a few frames.
    task automatic test_register_settings();
        cfg_t settings[4];
        settings[0] = {4{8'h00}};
        settings[1] = {4{8'hFF}};
        settings[2] = {8'h55, 8'hAA, 8'h0F, 8'hF0};
        settings[3] = {START_FIRST_RST, START_SECOND_RST, END_FIRST_RST, END_SECOND_RST};
        stall_pct = 14;
        foreach (settings[i])
        begin
            apply_delimiters(settings[i]);
            send_frame(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), 32'd2,
                       END_GOOD, 1'b0);
            send_frame(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), 32'd1,
                       END_BAD_SECOND, 1'b0);
            send_frame(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), 32'd0,
                       END_REARM, 1'b0);
            send_frame(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), 32'd1,
                       END_GOOD, 1'b1);
        end
        stall_pct = 0;
    endtask

    // Mostly well-formed frames with random content and a spread of endings,
    // mixed with noise, under each idling pattern and several delimiter settings.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned pick;
        logic [31:0] len;
        frame_end_t  ending;
        bit          rearmed;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 62; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            if (p == 3)
                apply_delimiters({START_FIRST_RST, START_SECOND_RST,
                                  END_FIRST_RST, END_SECOND_RST});
            else if (p != 0)
                apply_delimiters($urandom);
            rearmed = 1'b0;
            goal    = framed_bytes + RANDOM_PER_PHASE;
            while (framed_bytes < goal)
            begin
                // Occasional line noise, which also breaks any pending re-arm.
                if ($urandom_range(99) < 20)
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(random_byte());
                    rearmed = 1'b0;
                end
                // Most frames are short; only a few approach the limit.
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(8);
                else if (pick < 90)
                    len = $urandom_range(9, 40);
                else if (pick < 92)
                    len = $urandom_range(200, 256);
                else if (pick < 96)
                    len = $urandom_range(257, 600);
                else
                    len = $urandom;
                pick = $urandom_range(99);
                if (pick < 70)
                    ending = END_GOOD;
                else if (pick < 80)
                    ending = END_BAD_FIRST;
                else if (pick < 90)
                    ending = END_REARM;
                else
                    ending = END_BAD_SECOND;
                send_frame(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), len,
                           ending, rearmed && $urandom_range(1));
                rearmed = (ending == END_REARM) && (len <= PAYLOAD_LIMIT_DEF);
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // The result side shuts for a long stretch while a long frame streams in,
    // so the block fills and stalls its input; then the sender waits for every
    // owed item before it starts again.
    task automatic test_backpressure();
        wait_idle();
        -> begin_hold;
        send_frame(8'h5A, 16'h1234, 32'd150, END_GOOD, 1'b0);
        wait_idle();
        send_frame(8'hA5, 16'h4321, 32'd3, END_GOOD, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_cases();
        test_repeated_start();
        test_bad_endings();
        test_length_limit();
        test_register_settings();
        test_random_traffic();
        test_backpressure();

        // Drain whatever is still owed, then allow the block's latency.
        wait_idle();
        if (pending_frame_items.size() != 0)
        begin
            $display("%0t ns: %0d expected items never arrived", $time,
                     pending_frame_items.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ delimited_frame_deframer_unit.f @@
+incdir+sv
sv/dfd_pkg.sv
sv/dfd_cfg.sv
sv/dfd_in_stage.sv
sv/dfd_core.sv
sv/delimited_frame_deframer_unit.sv
bench/delimited_frame_deframer_unit_tb.sv
